@@ hw/rtl/lphm_pkg.sv @@
// Shared types and codes for the linear probing hash map.
// Used by the controller, the datapath and the top level; depends on nothing.
package lphm_pkg;

    localparam logic [6:0] LIMIT_MAX   = 7'd100;
    localparam logic [6:0] LIMIT_RESET = 7'd75;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_LOOKUP = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_ABSENT  = 3'd1,
        ST_PRESENT = 3'd2,
        ST_FULL    = 3'd3,
        ST_NULL    = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD1,
        S_MOD2,
        S_MOD3,
        S_PRD,
        S_PCHK,
        S_SRD,
        S_SCHK,
        S_SCLR
    } t_state;

    typedef struct packed {
        logic    take;
        logic    clr_step;
        logic    load_home;
        logic    rd_probe;
        logic    probe_step;
        logic    wr_insert;
        logic    wr_remove;
        logic    rd_shift;
        logic    shift_step;
        logic    wr_hole;
        logic    wr_clear;
        logic    done;
        logic    found;
        t_status status;
    } t_cmd;

    typedef struct packed {
        t_action act;
        logic    val_null;
        logic    empty;
        logic    match;
        logic    probe_last;
        logic    full;
        logic    stays;
        logic    shift_end;
        logic    clr_last;
    } t_flags;

endpackage

@@ hw/rtl/linear_probe_hash_map.sv @@
// Linear probing hash map, one item at a time. Action three (none) and a null
// insert end without a table read; else the home slot is computed, slots are
// probed one read at a time, and a remove then reads the slots after the hole,
// up to and including the first empty one, and shifts entries back.
// The slot RAM has a single read port, so each probed slot is a separate read.
// Reset runs a clearing pass over all TABLE_SLOTS slots with busy high.
// Results are strobed for one cycle; the receiver cannot stall.
module linear_probe_hash_map #(
    parameter int TABLE_SLOTS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_wdata,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_action,
    input  logic [63:0] i_key,
    input  logic [31:0] i_key_hash,
    input  logic [31:0] i_value,
    output logic        o_strobe,
    output logic [2:0]  o_status,
    output logic [31:0] o_found_value
);

    lphm_pkg::t_cmd   cmd;
    lphm_pkg::t_flags flags;

    lphm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_flags (flags),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    lphm_dp #(.N(TABLE_SLOTS)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_action      (i_action),
        .i_key         (i_key),
        .i_key_hash    (i_key_hash),
        .i_value       (i_value),
        .i_cmd         (cmd),
        .o_flags       (flags),
        .o_strobe      (o_strobe),
        .o_status      (o_status),
        .o_found_value (o_found_value)
    );

endmodule

@@ hw/rtl/lphm_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module lphm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/lphm_mod.sv @@
// Hash to home slot reduction: hash modulo slot count by reciprocal multiply.
// Two register stages, result combinational after the second. No deps.
module lphm_mod #(
    parameter int N = 256
) (
    input  logic                 i_clk,
    input  logic [31:0]          i_hash,
    output logic [$clog2(N)-1:0] o_home
);

    localparam int AW = $clog2(N);
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / N);
    localparam logic [31:0] NC    = 32'(N);
    localparam logic [31:0] NC2   = 32'(2 * N);

    logic [63:0] r_prod;
    logic [31:0] r_h1;
    logic [31:0] r_qn;
    logic [31:0] r_h2;
    logic [31:0] n_qn;
    logic [31:0] rem;
    logic [31:0] rem_c;

    // quotient estimate falls short by at most two
    assign n_qn = r_prod[63:32] * NC;

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(i_hash) * 64'(RECIP);
        r_h1   <= i_hash;
        r_qn   <= n_qn;
        r_h2   <= r_h1;
    end

    always_comb begin
        rem = r_h2 - r_qn;
        priority if (rem >= NC2) begin
            rem_c = rem - NC2;
        end else if (rem >= NC) begin
            rem_c = rem - NC;
        end else begin
            rem_c = rem;
        end
    end

    assign o_home = rem_c[AW-1:0];

endmodule

@@ hw/rtl/lphm_dp.sv @@
// Datapath of the hash map: item registers, slot RAM, probe and shift pointers,
// entry count, load check and result registers. Uses lphm_pkg, lphm_ram, lphm_mod.
module lphm_dp #(
    parameter int N = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [6:0]        i_cfg_wdata,
    input  logic [1:0]        i_action,
    input  logic [63:0]       i_key,
    input  logic [31:0]       i_key_hash,
    input  logic [31:0]       i_value,
    input  lphm_pkg::t_cmd    i_cmd,
    output lphm_pkg::t_flags  o_flags,
    output logic              o_strobe,
    output logic [2:0]        o_status,
    output logic [31:0]       o_found_value
);

    localparam int AW = $clog2(N);
    localparam int CW = $clog2(N + 1);
    localparam int WW = AW + 128;
    localparam int LW = $clog2(N * 100 + 1);
    localparam logic [AW-1:0] LAST = AW'(N - 1);

    lphm_pkg::t_action r_action;
    logic [63:0]   r_key;
    logic [31:0]   r_h;
    logic [31:0]   r_value;
    logic [AW-1:0] r_home;
    logic [AW-1:0] r_idx;
    logic [AW-1:0] r_cnt;
    logic [AW-1:0] r_hole;
    logic [AW-1:0] r_j;
    logic [CW-1:0] r_n;
    logic [AW-1:0] r_clr;
    logic [CW-1:0] r_count;
    logic [6:0]    r_limit;
    logic          r_strobe;
    lphm_pkg::t_status r_status;
    logic [31:0]   r_found;

    logic [AW-1:0] mod_home;
    logic          ram_we;
    logic [AW-1:0] ram_wa;
    logic [WW-1:0] ram_wd;
    logic          ram_re;
    logic [AW-1:0] ram_ra;
    logic [WW-1:0] rd_data;
    logic [AW-1:0] rd_home;
    logic [31:0]   rd_hash;
    logic [63:0]   rd_key;
    logic [31:0]   rd_val;
    logic [6:0]    lim_c;
    logic [LW-1:0] load_lhs;
    logic [LW-1:0] load_rhs;
    logic [AW-1:0] dist_home;
    logic [AW-1:0] dist_j;

    function automatic logic [AW-1:0] nxt(input logic [AW-1:0] i);
        return (i == LAST) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [AW-1:0] ring(input logic [AW-1:0] f, input logic [AW-1:0] t);
        logic [AW:0] d;
        if (t >= f) begin
            d = {1'b0, t} - {1'b0, f};
        end else begin
            d = {1'b0, t} + (AW + 1)'(N) - {1'b0, f};
        end
        return d[AW-1:0];
    endfunction

    lphm_mod #(.N(N)) u_mod (
        .i_clk  (i_clk),
        .i_hash (r_h),
        .o_home (mod_home)
    );

    lphm_ram #(.WIDTH(WW), .DEPTH(N)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_wa),
        .i_wdata (ram_wd),
        .i_re    (ram_re),
        .i_raddr (ram_ra),
        .o_rdata (rd_data)
    );

    assign rd_home = rd_data[WW-1:128];
    assign rd_hash = rd_data[127:96];
    assign rd_key  = rd_data[95:32];
    assign rd_val  = rd_data[31:0];

    assign ram_re = i_cmd.rd_probe | i_cmd.rd_shift;
    assign ram_ra = i_cmd.rd_shift ? r_j : r_idx;

    always_comb begin
        ram_we = 1'b1;
        ram_wa = r_idx;
        ram_wd = '0;
        priority if (i_cmd.clr_step) begin
            ram_wa = r_clr;
        end else if (i_cmd.wr_insert) begin
            ram_wd = {r_home, r_h, r_key, r_value};
        end else if (i_cmd.wr_remove) begin
            ram_wa = r_idx;
        end else if (i_cmd.wr_hole) begin
            ram_wa = r_hole;
            ram_wd = rd_data;
        end else if (i_cmd.wr_clear) begin
            ram_wa = r_j;
        end else begin
            ram_we = 1'b0;
        end
    end

    assign lim_c     = (r_limit > lphm_pkg::LIMIT_MAX) ? lphm_pkg::LIMIT_MAX : r_limit;
    assign load_lhs  = LW'(r_count) * LW'(100);
    assign load_rhs  = LW'(N) * LW'(lim_c);
    assign dist_home = ring(r_hole, rd_home);
    assign dist_j    = ring(r_hole, r_j);

    always_comb begin
        o_flags.act        = r_action;
        o_flags.val_null   = (r_value == 32'd0);
        o_flags.empty      = (rd_hash == 32'd0);
        o_flags.match      = (rd_hash == r_h) && (rd_key == r_key);
        o_flags.probe_last = (r_cnt == LAST);
        o_flags.full       = (load_lhs >= load_rhs);
        o_flags.stays      = (dist_home != '0) && (dist_home <= dist_j);
        o_flags.shift_end  = (r_n == CW'(N));
        o_flags.clr_last   = (r_clr == LAST);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_limit  <= lphm_pkg::LIMIT_RESET;
            r_clr    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.done;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (i_cmd.clr_step) begin
                r_clr <= nxt(r_clr);
            end
            if (i_cmd.wr_insert) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.wr_remove && r_count != '0) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_action <= lphm_pkg::t_action'(i_action);
            r_key    <= i_key;
            r_h      <= (i_key_hash == 32'd0) ? 32'd1 : i_key_hash;
            r_value  <= i_value;
        end
        if (i_cmd.load_home) begin
            r_home <= mod_home;
            r_idx  <= mod_home;
            r_cnt  <= '0;
        end
        if (i_cmd.probe_step) begin
            r_idx <= nxt(r_idx);
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.wr_remove) begin
            r_hole <= r_idx;
            r_j    <= nxt(r_idx);
            r_n    <= '0;
        end
        if (i_cmd.shift_step) begin
            r_j <= nxt(r_j);
            r_n <= r_n + 1'b1;
        end
        // the moved entry left a new hole at j
        if (i_cmd.wr_clear) begin
            r_hole <= r_j;
            r_j    <= nxt(r_j);
            r_n    <= r_n + 1'b1;
        end
        if (i_cmd.done) begin
            r_status <= i_cmd.status;
            r_found  <= i_cmd.found ? rd_val : 32'd0;
        end
    end

    assign o_strobe      = r_strobe;
    assign o_status      = r_status;
    assign o_found_value = r_found;

endmodule

@@ hw/rtl/lphm_ctrl.sv @@
// Controller of the hash map: clearing pass, home slot wait, probe loop and
// backward-shift loop. Uses lphm_pkg; drives the datapath by commands.
module lphm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  lphm_pkg::t_flags  i_flags,
    output lphm_pkg::t_cmd    o_cmd,
    output logic              o_busy
);

    lphm_pkg::t_state r_state;
    lphm_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lphm_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != lphm_pkg::S_IDLE);

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_cmd.status = lphm_pkg::ST_OK;
        unique case (r_state)
            lphm_pkg::S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_flags.clr_last) begin
                    n_state = lphm_pkg::S_IDLE;
                end
            end
            lphm_pkg::S_IDLE: begin
                if (i_start) begin
                    o_cmd.take = 1'b1;
                    n_state    = lphm_pkg::S_MOD1;
                end
            end
            lphm_pkg::S_MOD1: begin
                priority if (i_flags.act == lphm_pkg::ACT_NONE) begin
                    o_cmd.done = 1'b1;
                    n_state    = lphm_pkg::S_IDLE;
                end else if (i_flags.act == lphm_pkg::ACT_INSERT && i_flags.val_null) begin
                    o_cmd.done   = 1'b1;
                    o_cmd.status = lphm_pkg::ST_NULL;
                    n_state      = lphm_pkg::S_IDLE;
                end else begin
                    n_state = lphm_pkg::S_MOD2;
                end
            end
            lphm_pkg::S_MOD2: begin
                n_state = lphm_pkg::S_MOD3;
            end
            lphm_pkg::S_MOD3: begin
                o_cmd.load_home = 1'b1;
                n_state         = lphm_pkg::S_PRD;
            end
            lphm_pkg::S_PRD: begin
                o_cmd.rd_probe = 1'b1;
                n_state        = lphm_pkg::S_PCHK;
            end
            lphm_pkg::S_PCHK: begin
                if (i_flags.empty || i_flags.match || i_flags.probe_last) begin
                    n_state = lphm_pkg::S_IDLE;
                    unique case (i_flags.act)
                        lphm_pkg::ACT_INSERT: begin
                            o_cmd.done = 1'b1;
                            priority if (i_flags.match) begin
                                o_cmd.status = lphm_pkg::ST_PRESENT;
                            end else if (i_flags.full || !i_flags.empty) begin
                                o_cmd.status = lphm_pkg::ST_FULL;
                            end else begin
                                o_cmd.wr_insert = 1'b1;
                            end
                        end
                        lphm_pkg::ACT_LOOKUP: begin
                            o_cmd.done = 1'b1;
                            if (i_flags.match) begin
                                o_cmd.found = 1'b1;
                            end else begin
                                o_cmd.status = lphm_pkg::ST_ABSENT;
                            end
                        end
                        lphm_pkg::ACT_REMOVE: begin
                            if (i_flags.match) begin
                                o_cmd.wr_remove = 1'b1;
                                n_state         = lphm_pkg::S_SRD;
                            end else begin
                                o_cmd.done   = 1'b1;
                                o_cmd.status = lphm_pkg::ST_ABSENT;
                            end
                        end
                        default: begin
                            o_cmd.done = 1'b1;
                        end
                    endcase
                end else begin
                    o_cmd.probe_step = 1'b1;
                    n_state          = lphm_pkg::S_PRD;
                end
            end
            lphm_pkg::S_SRD: begin
                if (i_flags.shift_end) begin
                    o_cmd.done = 1'b1;
                    n_state    = lphm_pkg::S_IDLE;
                end else begin
                    o_cmd.rd_shift = 1'b1;
                    n_state        = lphm_pkg::S_SCHK;
                end
            end
            lphm_pkg::S_SCHK: begin
                priority if (i_flags.empty) begin
                    o_cmd.done = 1'b1;
                    n_state    = lphm_pkg::S_IDLE;
                end else if (i_flags.stays) begin
                    o_cmd.shift_step = 1'b1;
                    n_state          = lphm_pkg::S_SRD;
                end else begin
                    // move entry back into the hole
                    o_cmd.wr_hole = 1'b1;
                    n_state       = lphm_pkg::S_SCLR;
                end
            end
            lphm_pkg::S_SCLR: begin
                o_cmd.wr_clear = 1'b1;
                n_state        = lphm_pkg::S_SRD;
            end
            default: begin
                n_state = lphm_pkg::S_IDLE;
            end
        endcase
    end

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for linear_probe_hash_map: directed and random
// insert/lookup/remove beats checked against a behavioral map model.
// Depends on lphm_pkg and the linear_probe_hash_map RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 256;

    class map_scoreboard;
        logic [31:0] hash_q [SLOTS];
        logic [63:0] key_q [SLOTS];
        logic [31:0] val_q [SLOTS];
        int unsigned count;
        int unsigned limit;
        lphm_pkg::t_status exp_status [$];
        logic [31:0] exp_found [$];
        int unsigned errors;

        function void clear_map();
            for (int i = 0; i < SLOTS; i++) begin
                hash_q[i] = 0;
                key_q[i] = 0;
                val_q[i] = 0;
            end
            count = 0;
            limit = lphm_pkg::LIMIT_RESET;
            errors = 0;
        endfunction

        // Returns 1 on hit; where = slot of hit, first empty slot, or SLOTS.
        function bit probe(logic [63:0] k, logic [31:0] h, output int where);
            int idx;
            idx = int'(h % SLOTS);
            for (int n = 0; n < SLOTS; n++) begin
                if (hash_q[idx] == 0) begin
                    where = idx;
                    return 0;
                end
                if (hash_q[idx] == h && key_q[idx] == k) begin
                    where = idx;
                    return 1;
                end
                idx = (idx + 1) % SLOTS;
            end
            where = SLOTS;
            return 0;
        endfunction

        function int ring(int from, int to);
            return (to >= from) ? to - from : to + SLOTS - from;
        endfunction

        function void drop_at(int hole);
            int j;
            int home;
            int dh;
            bit stays;
            j = (hole + 1) % SLOTS;
            hash_q[hole] = 0;
            if (count > 0) count--;
            for (int n = 0; n < SLOTS && hash_q[j] != 0; n++) begin
                home = int'(hash_q[j] % SLOTS);
                dh = ring(hole, home);
                stays = (dh != 0) && (dh <= ring(hole, j));
                if (!stays) begin
                    hash_q[hole] = hash_q[j];
                    key_q[hole] = key_q[j];
                    val_q[hole] = val_q[j];
                    hash_q[j] = 0;
                    hole = j;
                end
                j = (j + 1) % SLOTS;
            end
        endfunction

        function void note_beat(lphm_pkg::t_action a, logic [63:0] k, logic [31:0] hin,
                                logic [31:0] v);
            lphm_pkg::t_status st;
            logic [31:0] fv;
            logic [31:0] h;
            int where;
            int lim;
            bit hit;
            st = lphm_pkg::ST_OK;
            fv = 0;
            h = (hin == 0) ? 32'd1 : hin;
            case (a)
                lphm_pkg::ACT_INSERT: begin
                    if (v == 0) begin
                        st = lphm_pkg::ST_NULL;
                    end else begin
                        lim = (limit > 100) ? 100 : limit;
                        hit = probe(k, h, where);
                        if (hit) st = lphm_pkg::ST_PRESENT;
                        else if (count * 100 >= SLOTS * lim || where >= SLOTS)
                            st = lphm_pkg::ST_FULL;
                        else begin
                            hash_q[where] = h;
                            key_q[where] = k;
                            val_q[where] = v;
                            count++;
                        end
                    end
                end
                lphm_pkg::ACT_LOOKUP: begin
                    if (probe(k, h, where)) fv = val_q[where];
                    else st = lphm_pkg::ST_ABSENT;
                end
                lphm_pkg::ACT_REMOVE: begin
                    if (probe(k, h, where)) drop_at(where);
                    else st = lphm_pkg::ST_ABSENT;
                end
                default: ;
            endcase
            exp_status.push_back(st);
            exp_found.push_back(fv);
        endfunction

        function void check_result(logic [2:0] st, logic [31:0] fv);
            lphm_pkg::t_status es;
            logic [31:0] ef;
            if (exp_status.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result status=%0d found=%h", st, fv);
                return;
            end
            es = exp_status.pop_front();
            ef = exp_found.pop_front();
            if (st !== es || fv !== ef) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: status exp %0d got %0d, found exp %h got %h",
                             es, st, ef, fv);
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_we = 0;
    logic [6:0]  cfg_wdata = 0;
    logic        start = 0;
    logic        busy;
    logic [1:0]  action = 0;
    logic [63:0] key = 0;
    logic [31:0] key_hash = 0;
    logic [31:0] value = 0;
    logic        strobe;
    logic [2:0]  status;
    logic [31:0] found_value;

    map_scoreboard sb;
    bit quiet;
    logic [63:0] pool_key [32];
    logic [31:0] pool_hash [32];

    always begin
        #2 clk = 1;
        #2 clk = 0;
    end

    linear_probe_hash_map #(.TABLE_SLOTS(SLOTS)) dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .start(start), .busy(busy), .i_action(action), .i_key(key),
        .i_key_hash(key_hash), .i_value(value), .o_strobe(strobe),
        .o_status(status), .o_found_value(found_value)
    );

    always @(posedge clk) begin
        if (rst_n && strobe) sb.check_result(status, found_value);
        if (rst_n && start && !busy)
            sb.note_beat(lphm_pkg::t_action'(action), key, key_hash, value);
    end

    // Return at the accepting edge; start stays high until the next falling edge.
    task automatic send(lphm_pkg::t_action a, logic [63:0] k, logic [31:0] h,
                        logic [31:0] v);
        @(negedge clk);
        while (!quiet && $urandom_range(99) < 12) begin
            start <= 0;
            @(negedge clk);
        end
        start <= 1;
        action <= a;
        key <= k;
        key_hash <= h;
        value <= v;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic wait_drain();
        @(negedge clk);
        start <= 0;
        while (sb.exp_status.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        while (busy) @(negedge clk);
    endtask

    // Drain, let the block settle, then write the limit while idle.
    task automatic set_limit(logic [6:0] lim);
        wait_drain();
        cfg_we <= 1;
        cfg_wdata <= lim;
        @(posedge clk);
        sb.limit = lim;
        @(negedge clk);
        cfg_we <= 0;
    endtask

    task automatic random_beat(int nkeys);
        int p;
        int r;
        logic [31:0] v;
        p = $urandom_range(nkeys - 1);
        r = $urandom_range(99);
        v = ($urandom_range(19) == 0) ? 32'd0 : $urandom;
        if (r < 3)
            send(lphm_pkg::ACT_NONE, {$urandom, $urandom}, $urandom, $urandom);
        else if (r < 10)
            send(lphm_pkg::t_action'($urandom_range(2)), {$urandom, $urandom}, $urandom, v);
        else if (r < 50) send(lphm_pkg::ACT_INSERT, pool_key[p], pool_hash[p], v);
        else if (r < 78) send(lphm_pkg::ACT_LOOKUP, pool_key[p], pool_hash[p], v);
        else send(lphm_pkg::ACT_REMOVE, pool_key[p], pool_hash[p], v);
    endtask

    initial begin
        sb = new();
        sb.clear_map();
        quiet = 0;
        for (int i = 0; i < 32; i++) begin
            pool_key[i] = {$urandom, $urandom};
            // Narrow home range to build long clusters and wraps.
            pool_hash[i] = ($urandom_range(3) == 0) ? $urandom
                         : {8'($urandom_range(3)), 16'd0, 8'hFC}
                           + 32'($urandom_range(6));
        end
        pool_hash[0] = 32'd0;
        pool_hash[1] = 32'd1;
        pool_hash[2] = 32'hFFFF_FFFF;
        pool_key[3] = 64'hFFFF_FFFF_FFFF_FFFF;
        pool_key[4] = 64'd0;
        repeat (4) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);
        while (busy) @(negedge clk);

        // Directed: each action, null value, duplicate, absent, zero hash, wrap.
        send(lphm_pkg::ACT_INSERT, pool_key[0], pool_hash[0], 32'hFFFF_FFFF);
        send(lphm_pkg::ACT_LOOKUP, pool_key[1], pool_hash[1], 0);
        send(lphm_pkg::ACT_LOOKUP, pool_key[0], pool_hash[0], 0);
        send(lphm_pkg::ACT_INSERT, pool_key[3], 32'h0000_00FF, 32'd1);
        send(lphm_pkg::ACT_INSERT, pool_key[4], 32'h0000_01FF, 32'd2);
        send(lphm_pkg::ACT_INSERT, pool_key[3], 32'h0000_00FF, 32'd3);
        send(lphm_pkg::ACT_INSERT, pool_key[5], pool_hash[5], 32'd0);
        send(lphm_pkg::ACT_LOOKUP, pool_key[4], 32'h0000_01FF, 0);
        send(lphm_pkg::ACT_REMOVE, pool_key[3], 32'h0000_00FF, 0);
        send(lphm_pkg::ACT_LOOKUP, pool_key[4], 32'h0000_01FF, 0);
        send(lphm_pkg::ACT_REMOVE, pool_key[3], 32'h0000_00FF, 0);
        send(lphm_pkg::ACT_NONE, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(lphm_pkg::ACT_REMOVE, pool_key[0], pool_hash[0], 0);
        send(lphm_pkg::ACT_REMOVE, pool_key[4], 32'h0000_01FF, 0);

        // Low limits: zero and one percent.
        set_limit(7'd0);
        send(lphm_pkg::ACT_INSERT, pool_key[6], pool_hash[6], 32'd5);
        set_limit(7'd1);
        for (int i = 0; i < 5; i++)
            send(lphm_pkg::ACT_INSERT, {$urandom, $urandom}, $urandom, 32'd9);

        // Fill the whole table at a limit above one hundred, then probe.
        set_limit(7'd127);
        for (int i = 0; i < 258; i++)
            send(lphm_pkg::ACT_INSERT, {$urandom, $urandom}, $urandom, $urandom | 1);
        send(lphm_pkg::ACT_LOOKUP, pool_key[7], pool_hash[7], 0);
        send(lphm_pkg::ACT_REMOVE, pool_key[7], pool_hash[7], 0);
        wait_drain();

        // Pressure: hold off until all results are in, then continue.
        for (int i = 0; i < 300; i++)
            send(lphm_pkg::ACT_REMOVE, {$urandom, $urandom}, $urandom, 0);
        set_limit(7'd100);
        wait_drain();

        // Random phases at several limits, one without idling.
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: set_limit(7'd75);
                1: set_limit(7'd10);
                2: set_limit(7'd100);
                3: set_limit(7'd50);
                default: set_limit(7'd90);
            endcase
            quiet = (ph == 2);
            for (int i = 0; i < 200; i++) random_beat((ph == 1) ? 8 : 32);
        end
        quiet = 0;
        wait_drain();
        repeat (50) @(negedge clk);
        if (sb.errors == 0 && sb.exp_status.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("tb: failure");
        $finish;
    end
endmodule
